// ===== hw/rtl/clcd_pkg.sv =====
package clcd_pkg;

    localparam int COLUMNS = 8;
    localparam int ROWS    = 2;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int POS_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W   = 2;

    localparam logic [POS_W-1:0] LAST_CELL = POS_W'(CELLS - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);

    localparam logic [7:0] CMD_HOME = 8'h80;

    typedef enum logic [1:0] {
        FUNC_PUT  = 2'd0,
        FUNC_POS  = 2'd1,
        FUNC_TICK = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HOME   = 2'd1,
        MODE_ROWCHK = 2'd2,
        MODE_DATA   = 2'd3
    } mode_t;

    // One access to the character store per cycle at most.
    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [POS_W-1:0] raddr;
    } store_req_t;

    // Result produced by the sequencer in the transfer cycle.
    typedef struct packed {
        logic       strobe;
        logic       is_command;
        logic [7:0] cmd_byte;
        logic       from_mem;
    } emit_t;

    typedef struct packed {
        mode_t            mode;
        logic [POS_W-1:0] write_pos;
        logic             pending;
    } seq_stat_t;

    // Set-DDRAM-address command for the first cell of a row.
    function automatic logic [7:0] row_cmd(input logic [ROW_W-1:0] r);
        logic [7:0] offs;
        case (r)
            2'd0:    offs = 8'h00;
            2'd1:    offs = 8'h40;
            2'd2:    offs = 8'h14;
            default: offs = 8'h54;
        endcase
        return CMD_HOME + offs;
    endfunction

endpackage

// ===== hw/rtl/clcd_store.sv =====
module clcd_store
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output logic [7:0] rd_data
);

    logic [7:0]       mem [CELLS];
    logic [CELLS-1:0] valid_reg;
    logic [CELLS-1:0] valid_next;
    logic [7:0]       rd_raw_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_raw_reg <= mem[req.raddr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    // Cells never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.re)
            begin
                rd_valid_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : 8'h00;

endmodule

// ===== hw/rtl/clcd_seq.sv =====
module clcd_seq
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic [5:0] column,
    input  logic [1:0] row,
    output store_req_t req,
    output emit_t      emit,
    output seq_stat_t  stat
);

    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] write_pos_reg, write_pos_next;
    logic [POS_W-1:0] show_pos_reg, show_pos_next;
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic             pending_reg, pending_next;

    logic             is_put, is_pos, is_tick;
    logic             pos_ok;
    logic [8:0]       pos_lin;

    assign is_put  = take && (func == FUNC_PUT);
    assign is_pos  = take && (func == FUNC_POS);
    assign is_tick = take && (func == FUNC_TICK);

    assign pos_ok  = (7'(column) < 7'(COLUMNS)) && (3'(row) < 3'(ROWS));
    assign pos_lin = 9'(column) + 9'(row) * 9'(COLUMNS);

    // Next state of the refresh machine
    always_comb
    begin
        mode_next = mode_reg;
        if (is_tick)
        begin
            case (mode_reg)
                MODE_IDLE:   mode_next = pending_reg ? MODE_HOME : MODE_IDLE;
                MODE_HOME:   mode_next = MODE_ROWCHK;
                MODE_ROWCHK: mode_next = MODE_DATA;
                MODE_DATA:   mode_next = (show_pos_reg == LAST_CELL) ? MODE_IDLE
                                                                     : MODE_ROWCHK;
                default:     mode_next = MODE_IDLE;
            endcase
        end
    end

    // Datapath and outputs
    always_comb
    begin
        write_pos_next = write_pos_reg;
        show_pos_next  = show_pos_reg;
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        pending_next   = pending_reg;
        req            = '0;
        req.waddr      = write_pos_reg;
        req.wdata      = char_code;
        req.raddr      = show_pos_reg;
        emit           = '0;

        if (is_put)
        begin
            req.we         = 1'b1;
            write_pos_next = (write_pos_reg == LAST_CELL) ? '0 : write_pos_reg + 1'b1;
            if (last_char)
            begin
                pending_next = 1'b1;
            end
        end

        if (is_pos && pos_ok)
        begin
            write_pos_next = POS_W'(pos_lin);
        end

        if (is_tick)
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    pending_next = 1'b0;
                end
                MODE_HOME:
                begin
                    show_pos_next   = '0;
                    col_cnt_next    = '0;
                    row_cnt_next    = '0;
                    emit.strobe     = 1'b1;
                    emit.is_command = 1'b1;
                    emit.cmd_byte   = CMD_HOME;
                end
                MODE_ROWCHK:
                begin
                    if (col_cnt_reg == '0)
                    begin
                        emit.strobe     = 1'b1;
                        emit.is_command = 1'b1;
                        emit.cmd_byte   = row_cmd(row_cnt_reg);
                    end
                end
                MODE_DATA:
                begin
                    req.re        = 1'b1;
                    emit.strobe   = 1'b1;
                    emit.from_mem = 1'b1;
                    show_pos_next = show_pos_reg + 1'b1;
                    if (col_cnt_reg == LAST_COL)
                    begin
                        col_cnt_next = '0;
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        col_cnt_next = col_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    pending_next = pending_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            write_pos_reg <= '0;
            show_pos_reg  <= '0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            write_pos_reg <= write_pos_next;
            show_pos_reg  <= show_pos_next;
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            pending_reg   <= pending_next;
        end
    end

    assign stat.mode      = mode_reg;
    assign stat.write_pos = write_pos_reg;
    assign stat.pending   = pending_reg;

endmodule

// ===== hw/rtl/char_lcd_refresh_controller.sv =====
// Character LCD frame buffer with a refresh sequencer.
//
// Command channel: an item is transferred on a rising edge with start high
// and busy low. func selects put character (char_code, last_char), set write
// position (column, row; ignored when out of range) or one refresh tick.
// busy stays low: every item is taken in the cycle it is offered, so the
// block sustains one item per clock.
//
// Result channel: a tick item that yields a byte drives strobe high for
// exactly one cycle, in the cycle after its transfer, with is_command and
// lcd_byte. Results are registered on the way out of the block; the
// receiver has no way to stall them and must take each one when it appears.
//
// The buffer lives in a synchronous RAM (one write port, one registered read
// port). A data tick reads the cell at its transfer edge; the registered read
// data forms lcd_byte in the following cycle. A put writes at its transfer
// edge, so only one access reaches the RAM per edge and no forwarding is
// needed. Per-cell valid flops, cleared by reset, make the buffer read as
// zeros after rst_n without a clearing pass; control state resets to idle.
module char_lcd_refresh_controller
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic [5:0] column,
    input  logic [1:0] row,
    output logic       strobe,
    output logic       is_command,
    output logic [7:0] lcd_byte
);

    logic       take;
    store_req_t req;
    emit_t      emit;
    seq_stat_t  stat;
    logic [7:0] rd_data;

    logic       strobe_reg;
    logic       is_command_reg;
    logic [7:0] cmd_byte_reg;
    logic       from_mem_reg;

    // No item ever has to wait.
    assign busy = 1'b0;
    assign take = start && !busy;

    clcd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .func      (func),
        .char_code (char_code),
        .last_char (last_char),
        .column    (column),
        .row       (row),
        .req       (req),
        .emit      (emit),
        .stat      (stat)
    );

    clcd_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    // Register the result; data bytes come straight from the RAM
    // read register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit.strobe;
        end
    end

    always_ff @(posedge clk)
    begin
        is_command_reg <= emit.is_command;
        cmd_byte_reg   <= emit.cmd_byte;
        from_mem_reg   <= emit.from_mem;
    end

    assign strobe     = strobe_reg;
    assign is_command = is_command_reg;
    assign lcd_byte   = from_mem_reg ? rd_data : cmd_byte_reg;

    // A result only ever follows a tick transfer.
    a_strobe_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(take && (func == FUNC_TICK)))
        else $error("result without a tick transfer");

    // A data byte only follows a tick taken in the data step.
    a_data_from_data_step: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !is_command) |-> $past(stat.mode == MODE_DATA))
        else $error("data byte outside the data step");

    // Leaving the data step, for idle or the row check, only happens on a transfer.
    a_idle_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.mode == MODE_DATA && !take) |=> (stat.mode == MODE_DATA))
        else $error("refresh machine moved without a tick");

    // The write position stays on the screen.
    a_write_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (stat.write_pos <= LAST_CELL))
        else $error("write position off screen");

endmodule
